// File: design/fetp_pkg.sv
// ----------------------------------------------------------------------------
// fetp_pkg - shared definitions for the escape-time fractal pixel engine
// Register indexes, reset values, fixed-point constants and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fetp_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 3'd4;

    localparam int unsigned CFG_DATA_W = 32;

    // field widths
    localparam int unsigned COORD_W = 10;
    localparam int unsigned Q_W     = 32;
    localparam int unsigned STEP_W  = 31;
    localparam int unsigned COLOR_W = 8;
    localparam int unsigned ITER_W  = 8;
    localparam int unsigned IN_DATA_W  = 24;
    localparam int unsigned OUT_DATA_W = 40;

    // register reset values, Q4.28
    localparam logic signed [Q_W-1:0] RST_MIN_X  = -32'sd536870912;
    localparam logic signed [Q_W-1:0] RST_MIN_Y  = -32'sd335544320;
    localparam logic [STEP_W-1:0]     RST_STEP_X = 31'd1118481;
    localparam logic [STEP_W-1:0]     RST_STEP_Y = 31'd1118481;

    // Julia constant c = -0.75 + 0.06i
    localparam logic signed [Q_W-1:0] JULIA_CRE = -32'sd201326592;
    localparam logic signed [Q_W-1:0] JULIA_CIM = 32'sd16106127;

    // escape limits: |part| > 2.0 in Q4.28, |z|^2 > 4.0 in Q8.56
    localparam logic [63:0] ESC_SQ = 64'h0400_0000_0000_0000;

    localparam int unsigned DEFAULT_MAX_ITERATIONS = 255;

    localparam int unsigned SUM_W = 42;

    // clamp a mapped coordinate into the signed Q4.28 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SUM_W-1:0] v);
        logic signed [Q_W-1:0] res;
        if (v > 42'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -42'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/fractal_escape_time_pixel.sv
// ----------------------------------------------------------------------------
// fractal_escape_time_pixel - Mandelbrot / Julia escape-time pixel engine
// Maps a pixel to a Q4.28 complex point and iterates z = z*z + c on one
// shared complex multiply unit until escape or the iteration limit.
// ----------------------------------------------------------------------------
// Each pixel makes n passes through the multiply unit: k + 1 when a part
// leaves the escape box, k + 2 when |z|^2 > 4, MAX_ITERATIONS + 1 without
// escape. A new pixel is taken only in ST_IDLE, once the last result has gone
// to the output register; each pass runs ST_MUL to form a*a, b*b and a*b, then
// ST_UPD to update z and run the escape test.
// Reset (synchronous, active low) loads the default view and Mandelbrot mode.
`default_nettype none

module fractal_escape_time_pixel #(
    parameter int unsigned MAX_ITERATIONS = fetp_pkg::DEFAULT_MAX_ITERATIONS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [fetp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fetp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  wire logic                            i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // [9:0] column, [19:10] row, [23:20] zero
    input  wire logic [fetp_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // result output
    output logic                                 o_m_axis_tvalid,
    input  wire logic                            i_m_axis_tready,
    // [7:0] iterations, [8] escaped, [16:9] red, [24:17] green,
    // [32:25] blue, [39:33] zero
    output logic [fetp_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    import fetp_pkg::*;

    localparam int unsigned CW = $clog2(MAX_ITERATIONS + 1);
    localparam int unsigned HW = CW + 6;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ITERATIONS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MAP  = 3'd1;
    localparam logic [2:0] ST_LOAD = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    // configuration registers
    logic                    r_mode;
    logic signed [Q_W-1:0]   r_min_x;
    logic signed [Q_W-1:0]   r_min_y;
    logic [STEP_W-1:0]       r_step_x;
    logic [STEP_W-1:0]       r_step_y;

    // sequencer and datapath registers
    logic [2:0]              r_state, n_state;
    logic [COORD_W-1:0]      r_col, r_row;
    logic signed [Q_W-1:0]   r_a, n_a;
    logic signed [Q_W-1:0]   r_b, n_b;
    logic signed [Q_W-1:0]   r_cre, n_cre;
    logic signed [Q_W-1:0]   r_cim, n_cim;
    logic signed [63:0]      r_p0, r_p1, r_p2;
    logic [CW-1:0]           r_cnt, n_cnt;
    logic [CW-1:0]           r_res_k, n_res_k;
    logic                    r_res_esc, n_res_esc;
    logic                    r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data, n_out_data;

    // shared multiply unit
    logic signed [Q_W-1:0]   w_op0a, w_op0b, w_op1a, w_op1b;
    logic signed [63:0]      w_m0, w_m1, w_m2;

    logic signed [SUM_W-1:0] w_sum_x, w_sum_y;
    logic signed [Q_W-1:0]   w_px, w_py;
    logic [63:0]             w_mag;
    logic                    w_mag_esc;
    logic signed [63:0]      w_diff;
    logic signed [36:0]      w_na;
    logic signed [37:0]      w_nb;
    logic                    w_bound_esc;
    logic [15:0]             w_k16;
    logic [ITER_W-1:0]       w_iter;
    logic [HW-1:0]           w_k10;
    logic [HW-1:0]           w_h;
    logic [COLOR_W-1:0]      w_red, w_green, w_blue;
    logic                    w_in_fire;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;

    // operand select: pixel mapping in ST_MAP, complex square otherwise
    always_comb begin
        if (r_state == ST_MAP) begin
            w_op0a = $signed({{(Q_W-COORD_W){1'b0}}, r_col});
            w_op0b = $signed({1'b0, r_step_x});
            w_op1a = $signed({{(Q_W-COORD_W){1'b0}}, r_row});
            w_op1b = $signed({1'b0, r_step_y});
        end else begin
            w_op0a = r_a;
            w_op0b = r_a;
            w_op1a = r_b;
            w_op1b = r_b;
        end
    end

    assign w_m0 = w_op0a * w_op0b;
    assign w_m1 = w_op1a * w_op1b;
    assign w_m2 = r_a * r_b;

    // point mapping with saturation
    assign w_sum_x = SUM_W'(r_min_x) + $signed(r_p0[SUM_W-1:0]);
    assign w_sum_y = SUM_W'(r_min_y) + $signed(r_p1[SUM_W-1:0]);
    assign w_px    = sat_q(w_sum_x);
    assign w_py    = sat_q(w_sum_y);

    // |z|^2 of the previous update comes from this pass's squares
    assign w_mag     = r_p0 + r_p1;
    assign w_mag_esc = (r_cnt != '0) && (w_mag > ESC_SQ);

    assign w_diff = r_p0 - r_p1;
    assign w_na   = 37'(w_diff >>> 28) + 37'(r_cre);
    assign w_nb   = 38'(r_p2 >>> 27) + 38'(r_cim);
    assign w_bound_esc = (w_na > 37'sd536870912) || (w_na < -37'sd536870912) ||
                         (w_nb > 38'sd536870912) || (w_nb < -38'sd536870912);

    // colour from the final count
    assign w_k16   = 16'(r_res_k);
    assign w_iter  = (w_k16 > 16'd255) ? 8'd255 : w_k16[ITER_W-1:0];
    assign w_k10   = HW'({r_res_k, 3'b000}) + HW'({r_res_k, 1'b0});
    assign w_h     = HW'(255) - w_k10;

    always_comb begin
        w_red   = '0;
        w_green = '0;
        w_blue  = '0;
        if (r_res_esc) begin
            if (r_mode) begin
                w_red = 8'd255;
            end else begin
                w_red   = w_h[COLOR_W-1:0];
                w_green = w_h[COLOR_W-1:0];
                w_blue  = w_h[HW-1] ? 8'd255 : 8'd0;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_cre       = r_cre;
        n_cim       = r_cim;
        n_cnt       = r_cnt;
        n_res_k     = r_res_k;
        n_res_esc   = r_res_esc;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_state = ST_MAP;
                end
            end
            ST_MAP: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_a   = w_px;
                n_b   = w_py;
                n_cre = r_mode ? JULIA_CRE : w_px;
                n_cim = r_mode ? JULIA_CIM : w_py;
                n_cnt = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (w_mag_esc) begin
                    n_res_k   = r_cnt - 1'b1;
                    n_res_esc = 1'b1;
                    n_state   = ST_DONE;
                end else if (r_cnt == MAX_CNT) begin
                    n_res_k   = r_cnt;
                    n_res_esc = 1'b0;
                    n_state   = ST_DONE;
                end else if (w_bound_esc) begin
                    n_res_k   = r_cnt;
                    n_res_esc = 1'b1;
                    n_state   = ST_DONE;
                end else begin
                    n_a     = w_na[Q_W-1:0];
                    n_b     = w_nb[Q_W-1:0];
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, w_blue, w_green, w_red, r_res_esc, w_iter};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b0;
            r_min_x     <= RST_MIN_X;
            r_min_y     <= RST_MIN_Y;
            r_step_x    <= RST_STEP_X;
            r_step_y    <= RST_STEP_Y;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE:   r_mode   <= i_cfg_data[0];
                    REG_MIN_X:  r_min_x  <= $signed(i_cfg_data);
                    REG_MIN_Y:  r_min_y  <= $signed(i_cfg_data);
                    REG_STEP_X: r_step_x <= i_cfg_data[STEP_W-1:0];
                    REG_STEP_Y: r_step_y <= i_cfg_data[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_col <= i_s_axis_tdata[COORD_W-1:0];
            r_row <= i_s_axis_tdata[2*COORD_W-1:COORD_W];
        end
        if (r_state == ST_MAP || r_state == ST_MUL) begin
            r_p0 <= w_m0;
            r_p1 <= w_m1;
            r_p2 <= w_m2;
        end
        r_a        <= n_a;
        r_b        <= n_b;
        r_cre      <= n_cre;
        r_cim      <= n_cim;
        r_res_k    <= n_res_k;
        r_res_esc  <= n_res_esc;
        r_out_data <= n_out_data;
    end

    // after the first update z stays inside the escape box
    a_z_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL && r_cnt != '0) |->
            (r_a <= 32'sd536870912 && r_a >= -32'sd536870912 &&
             r_b <= 32'sd536870912 && r_b >= -32'sd536870912))
        else $error("iterate left the escape box without stopping");

    a_cnt_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MAX_CNT)
        else $error("iteration count ran past the limit");

    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire |=> (r_state == ST_MAP))
        else $error("accepted pixel did not start mapping");

    a_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tdata[8]) |-> (o_m_axis_tdata[32:9] == '0))
        else $error("non-escaped pixel carries colour");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && (!r_out_valid || i_m_axis_tready)) |=>
            (r_out_valid && r_state == ST_IDLE))
        else $error("finished pixel not moved to the output register");

endmodule

`default_nettype wire
